### design/sbxperm_pkg.sv
`timescale 1ns / 1ps

package sbxperm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ID_W = 22;
  localparam int VAL_W = 32;
  localparam int PORT_W = 16;

  // request modes
  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_CHECK  = 3'd1;
  localparam logic [2:0] MODE_GRANT  = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  // permission kinds
  localparam logic [2:0] KIND_LISTEN  = 3'd0;
  localparam logic [2:0] KIND_BIND    = 3'd1;
  localparam logic [2:0] KIND_IOCTL   = 3'd2;
  localparam logic [2:0] KIND_FCNTL   = 3'd3;
  localparam logic [2:0] KIND_FORK    = 3'd4;
  localparam logic [2:0] KIND_DISABLE = 3'd5;

  // result status
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              locked;
    logic              disabled;
    logic              may_fork;
    logic [VAL_W-1:0]  ioctl_code;
    logic [VAL_W-1:0]  fcntl_code;
    logic [PORT_W-1:0] listen_port;
    logic [PORT_W-1:0] bind_port;
  } thr_entry_t;

  // one-shot grant applied to an unlocked entry
  function automatic thr_entry_t apply_grant(input thr_entry_t e, input logic [2:0] kind,
                                             input logic [VAL_W-1:0] value);
    thr_entry_t r;
    r = e;
    case (kind)
      KIND_LISTEN: r.listen_port = value[PORT_W-1:0];
      KIND_BIND:   r.bind_port = value[PORT_W-1:0];
      KIND_IOCTL:  r.ioctl_code = value;
      KIND_FCNTL:  r.fcntl_code = value;
      KIND_FORK:   r.may_fork = 1'b1;
      default:     r.disabled = 1'b1;
    endcase
    r.locked = 1'b1;
    return r;
  endfunction

  function automatic logic check_verdict(input thr_entry_t e, input logic [2:0] kind,
                                         input logic [VAL_W-1:0] value);
    logic v;
    case (kind)
      KIND_LISTEN: v = (value == {{(VAL_W-PORT_W){1'b0}}, e.listen_port});
      KIND_BIND:   v = (value == {{(VAL_W-PORT_W){1'b0}}, e.bind_port});
      KIND_IOCTL:  v = (value == e.ioctl_code);
      KIND_FCNTL:  v = (value == e.fcntl_code);
      KIND_FORK:   v = e.may_fork;
      default:     v = !e.disabled;
    endcase
    return v;
  endfunction

endpackage

### design/sandbox_permission_table.sv
`timescale 1ns / 1ps

// channel  | direction | tdata                       | tuser
// s_axis   | in        | pid, tid, value (zero pad)  | mode, kind
// m_axis   | out       | verdict (zero pad)          | status
//
// each request runs to its result before the next acceptance; for a lookup the id
// comparator walks the process table, then if needed the thread table, one entry per cycle
// out of a registered-read memory
// a new request is taken only in the idle state; the result register lets the next
// request start while the previous result waits on m_axis_tready
// rst is synchronous: both fill counts and the handshake state clear on it

module sandbox_permission_table
  import sbxperm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // pid [21:0], tid [43:22], value [75:44], zero
  input  logic [5:0]  s_axis_tuser,   // mode [2:0], kind [5:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // verdict [0], zero
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PSCAN = 3'd1;
  localparam logic [2:0] S_PDEC  = 3'd2;
  localparam logic [2:0] S_TSCAN = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [FILL_W-1:0] FULL = FILL_W'(TABLE_ENTRIES);

  logic [2:0]        state;
  logic [2:0]        mode;
  logic [2:0]        kind;
  logic [ID_W-1:0]   pid;
  logic [ID_W-1:0]   tid;
  logic [VAL_W-1:0]  value;
  logic [FILL_W-1:0] proc_fill;
  logic [FILL_W-1:0] thread_fill;
  logic [FILL_W-1:0] idx;
  logic              pend;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic              found;
  thr_entry_t        entry;
  logic              verdict;
  logic [1:0]        status;
  logic              out_verdict;
  logic [1:0]        out_status;
  logic              out_valid;

  logic [ID_W-1:0]   proc_mem [TABLE_ENTRIES];
  logic [ID_W-1:0]   proc_rdata;
  thr_entry_t        thr_mem [TABLE_ENTRIES];
  thr_entry_t        thr_rdata;

  logic [IDX_W-1:0]  rd_addr;
  logic [ID_W-1:0]   cmp_key;
  logic [ID_W-1:0]   cmp_data;
  logic [FILL_W-1:0] lim;
  logic              hit;
  logic              more;

  logic              proc_we;
  logic              thr_we;
  logic [IDX_W-1:0]  thr_waddr;
  thr_entry_t        thr_wdata;
  thr_entry_t        fresh;
  logic              act_verdict;
  logic [1:0]        act_status;
  logic              thr_grow;
  logic              out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_verdict};
  assign m_axis_tuser  = out_status;
  assign out_free      = !out_valid || m_axis_tready;

  // shared id comparator, walking one table entry per cycle
  assign rd_addr  = idx[IDX_W-1:0];
  assign cmp_key  = (state == S_PSCAN) ? pid : tid;
  assign cmp_data = (state == S_PSCAN) ? proc_rdata : thr_rdata.id;
  assign lim      = (state == S_PSCAN) ? proc_fill : thread_fill;
  assign hit      = pend && (cmp_data == cmp_key);
  assign more     = idx < lim;

  always_ff @(posedge clk) begin
    proc_rdata <= proc_mem[rd_addr];
    if (proc_we) begin
      proc_mem[proc_fill[IDX_W-1:0]] <= pid;
    end
  end

  always_ff @(posedge clk) begin
    thr_rdata <= thr_mem[rd_addr];
    if (thr_we) begin
      thr_mem[thr_waddr] <= thr_wdata;
    end
  end

  always_comb begin
    fresh = '0;
    fresh.id = tid;
    fresh.disabled = 1'b1;
    proc_we = 1'b0;
    thr_we = 1'b0;
    thr_grow = 1'b0;
    thr_waddr = hit_idx;
    thr_wdata = entry;
    act_verdict = 1'b0;
    act_status = ST_DONE;
    if (state == S_ACT) begin
      case (mode)
        MODE_ADD: begin
          if (proc_fill == FULL) begin
            act_status = ST_FULL;
          end else begin
            proc_we = 1'b1;
            act_verdict = 1'b1;
          end
        end
        MODE_CHECK: begin
          act_verdict = found && check_verdict(entry, kind, value);
        end
        MODE_GRANT: begin
          if (!found) begin
            if (thread_fill == FULL) begin
              act_status = ST_FULL;
            end else begin
              thr_we = 1'b1;
              thr_grow = 1'b1;
              thr_waddr = thread_fill[IDX_W-1:0];
              thr_wdata = apply_grant(fresh, kind, value);
            end
          end else if (entry.locked) begin
            act_status = ST_IGNORED;
          end else begin
            thr_we = 1'b1;
            thr_wdata = apply_grant(entry, kind, value);
          end
        end
        MODE_REMOVE: begin
          if (!found) begin
            act_status = ST_IGNORED;
          end else begin
            thr_we = 1'b1;
            thr_wdata.disabled = 1'b1;
            thr_wdata.locked = 1'b0;
          end
        end
        default: begin
          act_status = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      proc_fill <= '0;
      thread_fill <= '0;
      idx <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pid <= s_axis_tdata[21:0];
            tid <= s_axis_tdata[43:22];
            value <= s_axis_tdata[75:44];
            mode <= s_axis_tuser[2:0];
            kind <= s_axis_tuser[5:3];
            idx <= '0;
            pend <= 1'b0;
            found <= 1'b0;
            verdict <= 1'b0;
            status <= (s_axis_tuser[2:0] > MODE_QUERY) ? ST_IGNORED : ST_DONE;
            case (s_axis_tuser[2:0])
              MODE_ADD: state <= S_ACT;
              MODE_CHECK, MODE_GRANT, MODE_REMOVE, MODE_QUERY: state <= S_PSCAN;
              default: state <= S_DONE;
            endcase
          end
        end
        S_PSCAN, S_TSCAN: begin
          if (hit) begin
            found <= 1'b1;
            hit_idx <= rd_idx;
            entry <= thr_rdata;
            pend <= 1'b0;
            state <= (state == S_PSCAN) ? S_PDEC : S_ACT;
          end else if (more) begin
            pend <= 1'b1;
            rd_idx <= idx[IDX_W-1:0];
            idx <= idx + 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            found <= 1'b0;
            state <= (state == S_PSCAN) ? S_PDEC : S_ACT;
          end
        end
        S_PDEC: begin
          idx <= '0;
          pend <= 1'b0;
          found <= 1'b0;
          case (mode)
            MODE_QUERY: begin
              verdict <= found;
              state <= S_DONE;
            end
            MODE_CHECK: begin
              if (!found) begin
                verdict <= 1'b1;
                state <= S_DONE;
              end else if (kind > KIND_DISABLE) begin
                status <= ST_IGNORED;
                state <= S_DONE;
              end else begin
                state <= S_TSCAN;
              end
            end
            MODE_GRANT: begin
              if (!found || kind > KIND_DISABLE ||
                  (kind <= KIND_BIND && value[VAL_W-1:PORT_W] != '0)) begin
                status <= ST_IGNORED;
                state <= S_DONE;
              end else begin
                state <= S_TSCAN;
              end
            end
            MODE_REMOVE: begin
              if (!found) begin
                status <= ST_IGNORED;
                state <= S_DONE;
              end else begin
                state <= S_TSCAN;
              end
            end
            default: begin
              status <= ST_IGNORED;
              state <= S_DONE;
            end
          endcase
        end
        S_ACT: begin
          verdict <= act_verdict;
          status <= act_status;
          if (proc_we) begin
            proc_fill <= proc_fill + 1'b1;
          end
          if (thr_grow) begin
            thread_fill <= thread_fill + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_verdict <= verdict;
            out_status <= status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    proc_fill <= FULL && thread_fill <= FULL)
    else $error("table fill count beyond table size");

  a_thread_fill_step: assert property (@(posedge clk) disable iff (rst)
    thr_grow |=> thread_fill == $past(thread_fill) + 1'b1)
    else $error("thread table did not grow on new entry");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state != S_IDLE)
    else $error("accepted request did not start");

  a_verdict_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == ST_DONE)
    else $error("positive verdict with non-done status");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("pending result dropped");
`endif

endmodule
